// ===== rtl/double_click_motor_sequencer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the double click motor sequencer
// Implication checks on the block's own clock and synchronous reset.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_CLICK_MOTOR_SEQUENCER_MACROS_SVH
`define DOUBLE_CLICK_MOTOR_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DCMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcms assertion failed");

// next-cycle implication
`define DCMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcms assertion failed");

`else

`define DCMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DCMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/dcms_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dcms_pkg
// Shared types and constants of the double click motor sequencer.
// ---------------------------------------------------------------------------
package dcms_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;

  typedef logic [CFG_W-1:0]     cfg_word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [1:0]           count_t;

  // register indexes
  localparam cfg_idx_t REG_RUN_LIMIT = 8'd0;
  localparam cfg_idx_t REG_CLICK_GAP = 8'd1;
  localparam cfg_idx_t REG_DEBOUNCE  = 8'd2;

  // reset values
  localparam cfg_word_t RUN_LIMIT_RST = 16'd30000;
  localparam cfg_word_t CLICK_GAP_RST = 16'd800;
  localparam cfg_word_t DEBOUNCE_RST  = 16'd50;

  // click counts
  localparam count_t CLICKS_NONE = 2'd0;
  localparam count_t CLICKS_RUN  = 2'd2;
  localparam count_t CLICKS_STOP = 2'd3;

  typedef struct packed {
    logic open_ev;
    logic close_ev;
  } press_t;

  typedef struct packed {
    logic   open_drive;
    logic   close_drive;
    logic   moving;
    count_t open_count;
    count_t close_count;
  } result_t;

endpackage

// ===== rtl/dcms_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dcms channel interfaces
// Tick input, result output and configuration write channels.
// ---------------------------------------------------------------------------
interface dcms_in_if;
  logic valid;
  logic ready;
  logic open_pressed;
  logic close_pressed;

  modport source (output valid, output open_pressed, output close_pressed, input ready);
  modport sink   (input valid, input open_pressed, input close_pressed, output ready);
endinterface

interface dcms_out_if;
  logic       valid;
  logic       ready;
  logic       open_drive;
  logic       close_drive;
  logic       moving;
  logic [1:0] open_count;
  logic [1:0] close_count;

  modport source (output valid, output open_drive, output close_drive, output moving,
                  output open_count, output close_count, input ready);
  modport sink   (input valid, input open_drive, input close_drive, input moving,
                  input open_count, input close_count, output ready);
endinterface

interface dcms_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/double_click_motor_sequencer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// double_click_motor_sequencer
// Two-button click-counting motor sequencer with debounce and run timeout.
// ---------------------------------------------------------------------------
// Usage:
//   in_if   : one word per 1 ms tick with the open and close button levels.
//   out_if  : one word per tick: both drives, the moving flag and the click
//             counts after that tick.
//   cfg_if  : register writes (0 run limit, 1 click gap, 2 debounce, all in
//             ms); ready is always high, other indexes are ignored. Write
//             only while no tick is in flight.
//   Path    : an accepted tick waits in the input register; its result word
//             is then held in the result register until it is taken.
//   Throughput: one tick per cycle, set by the single pass through the click
//             logic between the two registers; in_if.ready stays high while
//             the result register drains or is taken in the same cycle.
//   Stall   : when out_if.ready is low the result word holds, the input
//             register fills, and in_if.ready drops until the result moves.
//   Reset   : rst_n (synchronous, active low) releases both buttons, clears
//             all timers, counts and drives, empties both registers and loads
//             the register defaults 30000, 800 and 50.
// ---------------------------------------------------------------------------
`include "double_click_motor_sequencer_macros.svh"

module double_click_motor_sequencer
  import dcms_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  dcms_in_if.sink        in_if,
  dcms_out_if.source     out_if,
  dcms_cfg_if.sink       cfg_if
);

  cfg_word_t run_limit_r;
  cfg_word_t click_gap_r;
  cfg_word_t debounce_r;

  logic      s1_valid_r;
  logic      s1_open_r;
  logic      s1_close_r;
  logic      out_valid_r;
  result_t   out_r;
  result_t   core_res;
  press_t    press;
  logic      adv;

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_limit_r <= RUN_LIMIT_RST;
      click_gap_r <= CLICK_GAP_RST;
      debounce_r  <= DEBOUNCE_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_RUN_LIMIT: run_limit_r <= cfg_if.data;
        REG_CLICK_GAP: click_gap_r <= cfg_if.data;
        REG_DEBOUNCE:  debounce_r  <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // advance the input word when the result register is free or being taken
  assign adv         = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_open_r  <= in_if.open_pressed;
      s1_close_r <= in_if.close_pressed;
    end
  end

  dcms_button #(.TIMER_BITS(TIMER_BITS)) u_open_btn (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .level    (s1_open_r),
    .debounce (debounce_r),
    .press    (press.open_ev)
  );

  dcms_button #(.TIMER_BITS(TIMER_BITS)) u_close_btn (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .level    (s1_close_r),
    .debounce (debounce_r),
    .press    (press.close_ev)
  );

  dcms_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .press     (press),
    .run_limit (run_limit_r),
    .click_gap (click_gap_r),
    .res       (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= core_res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.open_drive  = out_r.open_drive;
  assign out_if.close_drive = out_r.close_drive;
  assign out_if.moving      = out_r.moving;
  assign out_if.open_count  = out_r.open_count;
  assign out_if.close_count = out_r.close_count;

  `DCMS_ASSERT_IMPLY(a_drives_exclusive, clk, rst_n, out_valid_r,
                     !(out_r.open_drive && out_r.close_drive))
  `DCMS_ASSERT_IMPLY(a_drive_needs_run, clk, rst_n,
                     out_valid_r && (out_r.open_drive || out_r.close_drive), out_r.moving)
  `DCMS_ASSERT_IMPLY(a_count_range, clk, rst_n, out_valid_r,
                     out_r.open_count != CLICKS_STOP && out_r.close_count != CLICKS_STOP)
  `DCMS_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, adv, out_valid_r)

endmodule

// ===== rtl/dcms_button.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dcms_button
// Debounced press detector: level history and edge timer of one button.
// ---------------------------------------------------------------------------
module dcms_button
  import dcms_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      level,
  input  cfg_word_t debounce,
  output logic      press
);

  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  logic                  prev_r;
  logic                  prev_nxt;
  logic [TIMER_BITS-1:0] age_r;
  logic [TIMER_BITS-1:0] age_nxt;
  logic [TIMER_BITS-1:0] age_inc;

  // saturate at all ones
  assign age_inc = (age_r == {TIMER_BITS{1'b1}}) ? age_r : age_r + 1'b1;

  always_comb begin
    prev_nxt = prev_r;
    age_nxt  = age_inc;
    press    = 1'b0;
    if (level != prev_r) begin
      press    = level && (CW'(age_inc) > CW'(debounce));
      age_nxt  = '0;
      prev_nxt = level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      age_r  <= '0;
    end else if (en) begin
      prev_r <= prev_nxt;
      age_r  <= age_nxt;
    end
  end

endmodule

// ===== rtl/dcms_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dcms_core
// Click counters, idle timers, run timer and drive outputs.
// ---------------------------------------------------------------------------
module dcms_core
  import dcms_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  press_t    press,
  input  cfg_word_t run_limit,
  input  cfg_word_t click_gap,
  output result_t   res
);

  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  count_t                oc_r, oc_nxt;
  count_t                cc_r, cc_nxt;
  logic [TIMER_BITS-1:0] oidle_r, oidle_nxt;
  logic [TIMER_BITS-1:0] cidle_r, cidle_nxt;
  logic [TIMER_BITS-1:0] run_age_r, run_age_nxt;
  logic                  run_r, run_nxt;
  logic                  oout_r, oout_nxt;
  logic                  cout_r, cout_nxt;

  always_comb begin
    oc_nxt      = oc_r;
    cc_nxt      = cc_r;
    run_nxt     = run_r;
    oout_nxt    = oout_r;
    cout_nxt    = cout_r;
    oidle_nxt   = (oidle_r == TMAX) ? oidle_r : oidle_r + 1'b1;
    cidle_nxt   = (cidle_r == TMAX) ? cidle_r : cidle_r + 1'b1;
    run_age_nxt = (run_age_r == TMAX) ? run_age_r : run_age_r + 1'b1;

    // open click first
    if (press.open_ev) begin
      oc_nxt   = oc_nxt + 1'b1;
      cc_nxt   = CLICKS_NONE;
      cout_nxt = 1'b0;
      unique case (oc_nxt)
        CLICKS_RUN: begin
          oout_nxt    = 1'b1;
          run_age_nxt = '0;
          run_nxt     = 1'b1;
        end
        CLICKS_STOP: begin
          oc_nxt   = CLICKS_NONE;
          oout_nxt = 1'b0;
          run_nxt  = 1'b0;
        end
        default: ;
      endcase
      oidle_nxt = '0;
    end

    if (press.close_ev) begin
      cc_nxt   = cc_nxt + 1'b1;
      oc_nxt   = CLICKS_NONE;
      oout_nxt = 1'b0;
      unique case (cc_nxt)
        CLICKS_RUN: begin
          cout_nxt    = 1'b1;
          run_age_nxt = '0;
          run_nxt     = 1'b1;
        end
        CLICKS_STOP: begin
          cc_nxt   = CLICKS_NONE;
          cout_nxt = 1'b0;
          run_nxt  = 1'b0;
        end
        default: ;
      endcase
      cidle_nxt = '0;
    end

    // run timeout stops everything
    if (run_nxt && (CW'(run_age_nxt) > CW'(run_limit))) begin
      oout_nxt = 1'b0;
      cout_nxt = 1'b0;
      oc_nxt   = CLICKS_NONE;
      cc_nxt   = CLICKS_NONE;
      run_nxt  = 1'b0;
    end

    // drop stale counts while idle
    if (!run_nxt) begin
      if (CW'(oidle_nxt) > CW'(click_gap)) oc_nxt = CLICKS_NONE;
      if (CW'(cidle_nxt) > CW'(click_gap)) cc_nxt = CLICKS_NONE;
    end
  end

  assign res.open_drive  = oout_nxt;
  assign res.close_drive = cout_nxt;
  assign res.moving      = run_nxt;
  assign res.open_count  = oc_nxt;
  assign res.close_count = cc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r      <= CLICKS_NONE;
      cc_r      <= CLICKS_NONE;
      oidle_r   <= '0;
      cidle_r   <= '0;
      run_age_r <= '0;
      run_r     <= 1'b0;
      oout_r    <= 1'b0;
      cout_r    <= 1'b0;
    end else if (en) begin
      oc_r      <= oc_nxt;
      cc_r      <= cc_nxt;
      oidle_r   <= oidle_nxt;
      cidle_r   <= cidle_nxt;
      run_age_r <= run_age_nxt;
      run_r     <= run_nxt;
      oout_r    <= oout_nxt;
      cout_r    <= cout_nxt;
    end
  end

endmodule
